FILE: rtl/tfl_pkg.sv
package tfl_pkg;

  // Default CORDIC iteration count (valid range 8..24)
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // CORDIC datapath width: speeds x256 plus gain headroom
  localparam int unsigned CW = 27;
  // Angle accumulator width, 2^-16 rad units
  localparam int unsigned ZW = 19;

  // Config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADING_GAIN     = 2'd0,
    CFG_TURN_RATE_LIMIT  = 2'd1,
    CFG_TURN_ACCEL_LIMIT = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] HEADING_GAIN_RST     = 16'd256;
  localparam logic [14:0] TURN_RATE_LIMIT_RST  = 15'd8192;
  localparam logic [15:0] TURN_ACCEL_LIMIT_RST = 16'd2560;

  // round(atan(2^-i) * 2^16)
  localparam logic [16:0] ATAN_TAB [24] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
    17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
  };

  // Fields that ride alongside the CORDIC pipe
  typedef struct packed {
    logic        trav_pos;   // travel speed > 0
    logic        err;        // invalid argument or config
    logic [15:0] prev;       // last turn rate
    logic [31:0] accel_dt;   // turn_accel_limit * time_step
  } side_t;

endpackage

FILE: rtl/tfl_cordic.sv
module tfl_cordic #(
  parameter int unsigned CORDIC_STEPS = tfl_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [tfl_pkg::CW-1:0]    in_x_i,
  input  logic signed [tfl_pkg::CW-1:0]    in_y_i,
  input  tfl_pkg::side_t                   in_side_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [tfl_pkg::ZW-1:0]    out_z_o,
  output tfl_pkg::side_t                   out_side_o
);
  import tfl_pkg::*;

  logic signed [CW-1:0] x_q [CORDIC_STEPS];
  logic signed [CW-1:0] y_q [CORDIC_STEPS];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS];
  side_t                side_q [CORDIC_STEPS];
  logic [CORDIC_STEPS-1:0] v_q;
  logic [CORDIC_STEPS-1:0] en;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    logic signed [CW-1:0] x_s, y_s, x_d, y_d;
    logic signed [ZW-1:0] z_s, z_d;
    side_t                side_s;
    logic                 v_s;
    logic                 rot_neg;
    logic signed [ZW-1:0] ang;

    if (k == 0) begin : g_first
      assign x_s    = in_x_i;
      assign y_s    = in_y_i;
      assign z_s    = '0;
      assign side_s = in_side_i;
      assign v_s    = in_valid_i;
    end else begin : g_next
      assign x_s    = x_q[k-1];
      assign y_s    = y_q[k-1];
      assign z_s    = z_q[k-1];
      assign side_s = side_q[k-1];
      assign v_s    = v_q[k-1];
    end

    if (k == CORDIC_STEPS - 1) begin : g_last_en
      assign en[k] = !v_q[k] || !out_stall_i;
    end else begin : g_mid_en
      assign en[k] = !v_q[k] || en[k+1];
    end

    assign ang = $signed({{(ZW-17){1'b0}}, ATAN_TAB[k]});

    // rotate towards y = 0; y > 0 drives the angle up
    always_comb begin
      rot_neg = !y_s[CW-1] && (y_s != '0);
      if (rot_neg) begin
        x_d = x_s + (y_s >>> k);
        y_d = y_s - (x_s >>> k);
        z_d = z_s + ang;
      end else begin
        x_d = x_s - (y_s >>> k);
        y_d = y_s + (x_s >>> k);
        z_d = z_s - ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        side_q[k] <= side_s;
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[CORDIC_STEPS-1];
  assign out_z_o     = z_q[CORDIC_STEPS-1];
  assign out_side_o  = side_q[CORDIC_STEPS-1];

endmodule

FILE: rtl/tape_follow_turn_rate_limiter_unit.sv
// chan dir    handshake                  payload
// in   sink   in_valid_i / in_stall_o    travel_speed_i side_speed_i last_turn_rate_i time_step_i
// out  source out_valid_o / out_stall_i  turn_rate_o status_o
// cfg  sink   cfg_we_i                   cfg_idx_i cfg_data_i
//
// One beat in per cycle, one beat out per cycle while out_stall_i is low; from the accepting
// edge to out_valid_o a beat passes the input register, one register per CORDIC iteration
// and four post stages.
// Reset clears the valid bits and loads the register defaults.
// Each stage holds while its successor is full and stalled; empty stages
// still fill, so bubbles close up under an output stall.
// in_stall_o is only high when every stage up to the output holds a beat.
module tape_follow_turn_rate_limiter_unit #(
  parameter int unsigned CORDIC_STEPS = tfl_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config
  input  logic                              cfg_we_i,
  input  logic [tfl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tfl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [15:0]                travel_speed_i,
  input  logic signed [15:0]                side_speed_i,
  input  logic signed [15:0]                last_turn_rate_i,
  input  logic [15:0]                       time_step_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                turn_rate_o,
  output logic                              status_o
);
  import tfl_pkg::*;

  // ---------------------------------------------------------------- config
  logic [15:0] heading_gain_q;
  logic [14:0] turn_rate_limit_q;
  logic [15:0] turn_accel_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_gain_q     <= HEADING_GAIN_RST;
      turn_rate_limit_q  <= TURN_RATE_LIMIT_RST;
      turn_accel_limit_q <= TURN_ACCEL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADING_GAIN:     heading_gain_q     <= cfg_data_i;
        CFG_TURN_RATE_LIMIT:  turn_rate_limit_q  <= cfg_data_i[14:0];
        CFG_TURN_ACCEL_LIMIT: turn_accel_limit_q <= cfg_data_i;
        default: ;  // out-of-range index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake chain
  logic en_p0, en_m1, en_m2, en_m3, en_m4;
  logic v_p0_q, v_m1_q, v_m2_q, v_m3_q, v_m4_q;
  logic cor_stall, cor_valid;

  assign en_m4      = !v_m4_q || !out_stall_i;
  assign en_m3      = !v_m3_q || en_m4;
  assign en_m2      = !v_m2_q || en_m3;
  assign en_m1      = !v_m1_q || en_m2;
  assign en_p0      = !v_p0_q || !cor_stall;
  assign in_stall_o = !en_p0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p0_q <= 1'b0;
      v_m1_q <= 1'b0;
      v_m2_q <= 1'b0;
      v_m3_q <= 1'b0;
      v_m4_q <= 1'b0;
    end else begin
      if (en_p0) v_p0_q <= in_valid_i;
      if (en_m1) v_m1_q <= cor_valid;
      if (en_m2) v_m2_q <= v_m1_q;
      if (en_m3) v_m3_q <= v_m2_q;
      if (en_m4) v_m4_q <= v_m3_q;
    end
  end

  // ---------------------------------------------------------------- P0: input register
  // CORDIC start vector is (|travel|, side) scaled by 2^8; accel*dt product formed here.
  logic [15:0]          trav_abs;
  logic signed [CW-1:0] x0_q, y0_q;
  side_t                side0_q;

  assign trav_abs = travel_speed_i[15] ? 16'(-travel_speed_i) : travel_speed_i;

  always_ff @(posedge clk_i) begin
    if (en_p0) begin
      x0_q <= $signed({{(CW-24){1'b0}}, trav_abs, 8'b0});
      y0_q <= $signed({{(CW-24){side_speed_i[15]}}, side_speed_i, 8'b0});
      side0_q.trav_pos <= !travel_speed_i[15] && (travel_speed_i != '0);
      side0_q.err      <= (travel_speed_i == '0) || (time_step_i == '0)
                          || (turn_accel_limit_q == '0);
      side0_q.prev     <= last_turn_rate_i;
      side0_q.accel_dt <= turn_accel_limit_q * time_step_i;
    end
  end

  // ---------------------------------------------------------------- CORDIC pipe
  logic signed [ZW-1:0] cor_z;
  side_t                cor_side;

  tfl_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_p0_q),
    .in_stall_o  (cor_stall),
    .in_x_i      (x0_q),
    .in_y_i      (y0_q),
    .in_side_i   (side0_q),
    .out_valid_o (cor_valid),
    .out_stall_i (!en_m1),
    .out_z_o     (cor_z),
    .out_side_o  (cor_side)
  );

  // ---------------------------------------------------------------- M1: gain multiply
  logic [ZW-2:0]  z_abs;
  logic [32:0]    chg_sum;
  logic [33:0]    mult_q;
  logic           zneg_q, trav_pos1_q, err1_q;
  logic [17:0]    chg_q;
  logic [15:0]    prev1_q;

  assign z_abs   = cor_z[ZW-1] ? (ZW-1)'(-cor_z) : cor_z[ZW-2:0];
  assign chg_sum = {1'b0, cor_side.accel_dt} + 33'd8192;

  always_ff @(posedge clk_i) begin
    if (en_m1) begin
      mult_q      <= heading_gain_q * z_abs;
      zneg_q      <= cor_z[ZW-1];
      trav_pos1_q <= cor_side.trav_pos;
      err1_q      <= cor_side.err;
      chg_q       <= chg_sum[31:14];  // max change, round half up
      prev1_q     <= cor_side.prev;
    end
  end

  // ---------------------------------------------------------------- M2: round, sign, slew window
  logic [34:0]          mag_sum;
  logic [20:0]          mag;
  logic signed [21:0]   target_q;
  logic signed [19:0]   prev_x, chg_x;
  logic signed [19:0]   lo_q, hi_q;
  logic                 err2_q;

  assign mag_sum = {1'b0, mult_q} + 35'd8192;
  assign mag     = mag_sum[34:14];          // nearest, ties away (on magnitude)
  assign prev_x  = 20'(signed'(prev1_q));
  assign chg_x   = $signed({2'b0, chg_q});

  always_ff @(posedge clk_i) begin
    if (en_m2) begin
      // negative when exactly one holds: angle negative, travel forward
      target_q <= (zneg_q ^ trav_pos1_q) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      lo_q     <= prev_x - chg_x;
      hi_q     <= prev_x + chg_x;
      err2_q   <= err1_q;
    end
  end

  // ---------------------------------------------------------------- M3: rate saturation
  logic signed [21:0] lim;
  logic signed [15:0] sat_q;
  logic signed [19:0] lo3_q, hi3_q;
  logic               err3_q;

  assign lim = $signed({7'b0, turn_rate_limit_q});

  always_ff @(posedge clk_i) begin
    if (en_m3) begin
      if (target_q > lim) begin
        sat_q <= lim[15:0];
      end else if (target_q < -lim) begin
        sat_q <= 16'(-lim);
      end else begin
        sat_q <= target_q[15:0];
      end
      lo3_q  <= lo_q;
      hi3_q  <= hi_q;
      err3_q <= err2_q;
    end
  end

  // ---------------------------------------------------------------- M4: slew clamp, output register
  logic signed [19:0] sat_x;
  logic signed [15:0] turn_rate_q;
  logic               status_q;

  assign sat_x = 20'(sat_q);

  always_ff @(posedge clk_i) begin
    if (en_m4) begin
      status_q <= err3_q;
      if (err3_q) begin
        turn_rate_q <= '0;
      end else if (sat_x < lo3_q) begin
        turn_rate_q <= lo3_q[15:0];
      end else if (sat_x > hi3_q) begin
        turn_rate_q <= hi3_q[15:0];
      end else begin
        turn_rate_q <= sat_q;
      end
    end
  end

  assign out_valid_o = v_m4_q;
  assign turn_rate_o = turn_rate_q;
  assign status_o    = status_q;

endmodule

FILE: rtl/tfl_chk.sv
module tfl_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [tfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [tfl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic signed [15:0]             travel_speed_i,
  input logic signed [15:0]             side_speed_i,
  input logic signed [15:0]             last_turn_rate_i,
  input logic [15:0]                    time_step_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [15:0]             turn_rate_o,
  input logic                           status_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(turn_rate_o) && $stable(status_o))
    else $error("output beat changed under stall");

  // error beats carry a zero command
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> turn_rate_o == '0)
    else $error("error beat with nonzero turn rate");

  // pipe only pushes back when the output is full and stalled
  a_no_spurious_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled with output free");

  // nothing leaves while reset is held
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind tape_follow_turn_rate_limiter_unit tfl_chk u_tfl_chk (.*);

FILE: dv/tape_follow_turn_rate_checker.sv
module tape_follow_turn_rate_checker
  import tfl_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic signed [15:0]    travel_speed_i,
  input  logic signed [15:0]    side_speed_i,
  input  logic signed [15:0]    last_turn_rate_i,
  input  logic [15:0]           time_step_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic signed [15:0]    turn_rate_i,
  input  logic                  status_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] turn_rate;
    logic               status;
  } turn_cmd_t;

  // atan(2^-i) in 2^-16 rad, rounded
  localparam longint ATAN_Q16 [24] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  logic [15:0] gain_q;
  logic [14:0] rate_lim_q;
  logic [15:0] accel_lim_q;

  turn_cmd_t pending_turn_cmds [$];
  int        mismatches;

  function automatic turn_cmd_t compute_turn_cmd(input logic signed [15:0] trav,
                                                 input logic signed [15:0] side,
                                                 input logic signed [15:0] last,
                                                 input logic [15:0]        dt);
    turn_cmd_t cmd;
    longint    x, y, z, dx, dy, mag, target, lim, chg, lo, hi;
    cmd.turn_rate = '0;
    cmd.status    = 1'b1;
    if (trav == 0 || dt == 0 || accel_lim_q == 0) return cmd;

    // vectoring CORDIC on (|travel|, side), both scaled by 2^8
    x = (trav < 0) ? -longint'(trav) : longint'(trav);
    x = x * 256;
    y = longint'(side) * 256;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ATAN_Q16[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_Q16[i];
      end
    end

    // magnitude rounded half away from zero, steer against the angle for forward travel
    mag    = longint'(gain_q) * ((z < 0) ? -z : z);
    mag    = (mag + 8192) >>> 14;
    target = (z < 0) ? -mag : mag;
    if (trav > 0) target = -target;
    lim = longint'(rate_lim_q);
    if (target > lim) target = lim;
    if (target < -lim) target = -lim;

    chg = (longint'(accel_lim_q) * longint'(dt) + 8192) >>> 14;
    lo  = longint'(last) - chg;
    hi  = longint'(last) + chg;
    if (target < lo) target = lo;
    else if (target > hi) target = hi;

    cmd.turn_rate = target[15:0];
    cmd.status    = 1'b0;
    return cmd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    turn_cmd_t exp_cmd;
    if (!rst_ni) begin
      pending_turn_cmds.delete();
      mismatches = 0;
      gain_q       <= HEADING_GAIN_RST;
      rate_lim_q   <= TURN_RATE_LIMIT_RST;
      accel_lim_q  <= TURN_ACCEL_LIMIT_RST;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_turn_cmds.size() == 0) begin
          $display("%0t: unexpected beat, turn_rate %0d status %0b",
                   $time, turn_rate_i, status_i);
          mismatches++;
        end else begin
          exp_cmd = pending_turn_cmds.pop_front();
          if (turn_rate_i !== exp_cmd.turn_rate) begin
            $display("%0t: turn_rate expected %0d, got %0d",
                     $time, exp_cmd.turn_rate, turn_rate_i);
            mismatches++;
          end
          if (status_i !== exp_cmd.status) begin
            $display("%0t: status expected %0b, got %0b",
                     $time, exp_cmd.status, status_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_turn_cmds.push_back(compute_turn_cmd(travel_speed_i, side_speed_i,
                                                     last_turn_rate_i, time_step_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEADING_GAIN:     gain_q      <= cfg_data_i;
          CFG_TURN_RATE_LIMIT:  rate_lim_q  <= cfg_data_i[14:0];
          CFG_TURN_ACCEL_LIMIT: accel_lim_q <= cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= pending_turn_cmds.size();
    end
  end

endmodule

FILE: dv/tape_follow_turn_rate_limiter_unit_test.sv
// Bench for the turn-rate limiter. The top only makes stimulus and gives
// the verdict; prediction and comparison live in the checker beside i_dut.
module tape_follow_turn_rate_limiter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tfl_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 9;
  localparam int LATENCY         = CORDIC_STEPS_DEF + 4;
  // long receiver hold-off, well past the pipe depth so in_stall_o rises
  localparam int HOLD_OFF_CYCLES = 400;
  // cycles with no beat moving on either channel before we give up
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_BEATS     = 255;
  // the one index the block has no register behind
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b1;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx          = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    travel_speed     = '0;
  logic signed [15:0]    side_speed       = '0;
  logic signed [15:0]    last_turn_rate   = '0;
  logic [15:0]           time_step        = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic signed [15:0]    turn_rate;
  logic                  status;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;
  int quiet_cycles   = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  tape_follow_turn_rate_limiter_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .travel_speed_i   (travel_speed),
    .side_speed_i     (side_speed),
    .last_turn_rate_i (last_turn_rate),
    .time_step_i      (time_step),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .turn_rate_o      (turn_rate),
    .status_o         (status)
  );

  tape_follow_turn_rate_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .travel_speed_i   (travel_speed),
    .side_speed_i     (side_speed),
    .last_turn_rate_i (last_turn_rate),
    .time_step_i      (time_step),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .turn_rate_i      (turn_rate),
    .status_i         (status),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Offer one beat after a random gap, then hold it until taken. Valid is
  // left high on return so back-to-back beats need no second assignment.
  task automatic send_beat(input logic signed [15:0] trav, input logic signed [15:0] side,
                           input logic signed [15:0] last, input logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    travel_speed   <= trav;
    side_speed     <= side;
    last_turn_rate <= last;
    time_step      <= dt;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Mostly well-formed beats with random content; a few zero-travel and
  // zero-step beats, and a mix of full-range and modest magnitudes so the
  // clamps are hit from both sides as well as missed.
  task automatic send_random_beat();
    logic signed [15:0] trav, side, last;
    logic [15:0]        dt;
    int unsigned        kind;
    kind = $urandom_range(99);
    trav = 16'($urandom());
    side = 16'($urandom());
    last = 16'($urandom());
    dt   = 16'($urandom());
    if (kind < 4) begin
      trav = '0;
    end else if (kind < 8) begin
      dt = '0;
    end else begin
      if ($urandom_range(3) == 0)
        trav = 16'(int'($urandom_range(1, 255)) * ($urandom_range(1) ? 1 : -1));
      if (trav == 0) trav = 16'sd1;
      if ($urandom_range(1)) side = 16'(int'($urandom_range(0, 4095)) - 2048);
      if ($urandom_range(1)) last = 16'(int'($urandom_range(0, 8191)) - 4096);
      if ($urandom_range(1)) dt = 16'($urandom_range(1, 2048));
    end
    send_beat(trav, side, last, dt);
  endtask

  // Only called with the pipe empty. The spare index is written too: the
  // block must ignore it.
  task automatic write_config(input logic [15:0] gain, input logic [15:0] rate_word,
                              input logic [15:0] accel);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_HEADING_GAIN;
    cfg_data <= gain;
    @(posedge clk_i);
    cfg_idx  <= CFG_TURN_RATE_LIMIT;
    cfg_data <= rate_word;
    @(posedge clk_i);
    cfg_idx  <= CFG_TURN_ACCEL_LIMIT;
    cfg_data <= accel;
    @(posedge clk_i);
    cfg_idx  <= CFG_IDX_SPARE;
    cfg_data <= 16'($urandom());
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // At least one edge first so the checker has seen the last beat in.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int beats);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (beats) send_random_beat();
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Receiver: random stalls, or one long hold-off when asked, counted here.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any accepted beat on either channel resets the count.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // falling edge at time zero so the asynchronous reset takes hold at once
    rst_ni <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats under the reset settings: invalid travel and step,
    // field extremes, the slew clamp from both ends, tiny side angles.
    send_beat(0, 100, 0, 1000);
    send_beat(4096, 100, 0, 0);
    send_beat(0, 0, 0, 0);
    send_beat(32767, 0, 0, 65535);
    send_beat(-32768, 32767, 0, 65535);
    send_beat(1, -32768, 0, 65535);
    send_beat(-1, 32767, 0, 65535);
    send_beat(-32768, -32768, 32767, 65535);
    send_beat(32767, 32767, -32768, 65535);
    send_beat(4096, 4096, 32767, 1);
    send_beat(4096, -4096, -32768, 1);
    send_beat(-4096, 0, 0, 100);
    send_beat(4096, 1, 0, 65535);
    send_beat(4096, -1, 0, 65535);
    send_beat(16'sh5555, 16'shAAAA, 16'sh5555, 16'hAAAA);
    send_beat(16'shAAAA, 16'sh5555, 16'shAAAA, 16'h5555);
    in_valid <= 1'b0;
    wait_drained();

    // zero accel limit: every beat flagged
    write_config(16'hFFFF, 16'hFFFF, 16'h0000);
    send_beat(4096, 2048, 0, 1000);
    send_beat(-32768, -32768, 32767, 65535);
    in_valid <= 1'b0;
    wait_drained();

    // top of every range; rate limit written with bit 15 set, so masked.
    // Sender flat out while the receiver holds off: the pipe fills and
    // in_stall_o has to rise.
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    hold_off_req = 1'b1;
    run_phase(0, 0, PHASE_BEATS);

    // bottom of every range that still leaves the block working
    write_config(16'h0000, 16'h0000, 16'h0001);
    run_phase(83, 0, PHASE_BEATS);

    write_config(16'($urandom_range(0, 4095)), 16'($urandom()),
                 16'($urandom_range(1, 65535)));
    run_phase(0, 83, PHASE_BEATS);

    write_config(16'($urandom()), 16'($urandom()), 16'($urandom_range(1, 65535)));
    run_phase(8, 8, PHASE_BEATS);

    write_config(16'($urandom()), 16'($urandom()), 16'h0000);
    run_phase(0, 0, PHASE_BEATS / 2);

    write_config(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 16383)),
                 16'($urandom_range(1, 8191)));
    run_phase(83, 0, PHASE_BEATS);

    write_config(16'($urandom()), 16'($urandom()), 16'($urandom_range(1, 65535)));
    run_phase(0, 83, PHASE_BEATS);

    write_config(HEADING_GAIN_RST, 16'(TURN_RATE_LIMIT_RST), TURN_ACCEL_LIMIT_RST);
    run_phase(8, 8, PHASE_BEATS);

    // let anything stray fall out of the pipe before judging
    repeat (2 * LATENCY) @(posedge clk_i);
    if (pending != 0) $display("%0t: %0d expected beats never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: tape_follow_turn_rate_limiter_unit.f
rtl/tfl_pkg.sv
rtl/tfl_cordic.sv
rtl/tape_follow_turn_rate_limiter_unit.sv
rtl/tfl_chk.sv
dv/tape_follow_turn_rate_checker.sv
dv/tape_follow_turn_rate_limiter_unit_test.sv
